FILE: hdl/qarc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_pkg
// Types, widths, codes and rounding helpers of the attitude rate controller.
// ----------------------------------------------------------------------------
package qarc_pkg;

  localparam int NStage = 6;
  localparam int FixW   = 16;
  localparam int ThrW   = 13;
  localparam int ProdW  = 32;
  localparam int SumW   = 34;
  localparam int RateMW = 51;
  localparam int DotMW  = 50;
  localparam int AccW   = 34;
  localparam int ThrMW  = 52;
  localparam int WideW  = 56;
  localparam int CfgIdxW = 2;

  localparam int RateShift = 28;
  localparam int DotShift  = 20;
  localparam int ThrShift  = 20;
  localparam int OffShift  = 16;

  localparam logic [FixW-1:0] InvTauRst = 16'd2560;
  localparam logic [FixW-1:0] GainRst   = 16'd4588;
  localparam logic [FixW-1:0] OffsetRst = 16'd6554;
  localparam logic [ThrW-1:0] ThrFull   = 13'd4096;

  typedef logic signed [FixW-1:0]  fix16_t;
  typedef logic [ThrW-1:0]         thr_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INV_TAU = 2'd0,
    CFG_GAIN    = 2'd1,
    CFG_OFFSET  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    fix16_t want_w;
    fix16_t want_x;
    fix16_t want_y;
    fix16_t want_z;
    fix16_t acc_x;
    fix16_t acc_y;
    fix16_t acc_z;
    fix16_t now_w;
    fix16_t now_x;
    fix16_t now_y;
    fix16_t now_z;
  } item_t;

  typedef struct packed {
    sum_t   ew;
    sum_t   ex;
    sum_t   ey;
    sum_t   ez;
    sum_t   zx;
    sum_t   zy;
    sum_t   zz;
    fix16_t ax;
    fix16_t ay;
    fix16_t az;
  } err_t;

  // arithmetic right shift with round half away from zero
  function automatic wide_t shr_round(wide_t v, int unsigned n);
    wide_t half;
    wide_t r;
    half = wide_t'(1) <<< (n - 1);
    if (v >= 0) begin
      r = (v + half) >>> n;
    end else begin
      r = (v + half - wide_t'(1)) >>> n;
    end
    return r;
  endfunction

  function automatic fix16_t sat16(wide_t v);
    fix16_t r;
    if (v > wide_t'(16'sh7fff)) begin
      r = 16'sh7fff;
    end else if (v < wide_t'(16'sh8000)) begin
      r = 16'sh8000;
    end else begin
      r = v[FixW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/qarc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_if
// Valid/ready channels for pose items and rate/thrust results.
// ----------------------------------------------------------------------------
interface qarc_in_if;
  logic                 valid;
  logic                 ready;
  qarc_pkg::fix16_t     want_w;
  qarc_pkg::fix16_t     want_x;
  qarc_pkg::fix16_t     want_y;
  qarc_pkg::fix16_t     want_z;
  qarc_pkg::fix16_t     acc_x;
  qarc_pkg::fix16_t     acc_y;
  qarc_pkg::fix16_t     acc_z;
  qarc_pkg::fix16_t     now_w;
  qarc_pkg::fix16_t     now_x;
  qarc_pkg::fix16_t     now_y;
  qarc_pkg::fix16_t     now_z;

  modport source (
    output valid, want_w, want_x, want_y, want_z, acc_x, acc_y, acc_z,
           now_w, now_x, now_y, now_z,
    input  ready
  );
  modport sink (
    input  valid, want_w, want_x, want_y, want_z, acc_x, acc_y, acc_z,
           now_w, now_x, now_y, now_z,
    output ready
  );
endinterface

interface qarc_out_if;
  logic                 valid;
  logic                 ready;
  qarc_pkg::fix16_t     roll_rate;
  qarc_pkg::fix16_t     pitch_rate;
  qarc_pkg::fix16_t     yaw_rate;
  qarc_pkg::thr_t       thrust;

  modport source (
    output valid, roll_rate, pitch_rate, yaw_rate, thrust,
    input  ready
  );
  modport sink (
    input  valid, roll_rate, pitch_rate, yaw_rate, thrust,
    output ready
  );
endinterface

FILE: hdl/quaternion_attitude_rate_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_controller
// Attitude error rate commands and normalized thrust from a pose pair.
// ----------------------------------------------------------------------------
// Six-stage pipeline, one transfer per cycle unless the output is stalled.
// Stages: part products, error quaternion and body z axis, gain multiplies,
// rounding and saturation (dot product reduction on the thrust side), thrust
// gain and offset, clamp into the output register. Every stage holds its own
// valid bit, so bubbles close up under output backpressure and new items are
// taken while a result waits. The user must write registers only while the
// pipe is empty, through cfg_we_i / cfg_idx_i / cfg_data_i; the block does not
// enforce this. An index past the last register is ignored.
module quaternion_attitude_rate_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qarc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [qarc_pkg::FixW-1:0]         cfg_data_i,
  qarc_in_if.sink                           in_i,
  qarc_out_if.source                        out_o
);
  import qarc_pkg::*;

  logic [FixW-1:0]   inv_tau_q, gain_q, offset_q;
  logic [NStage-1:0] v_q;
  logic [NStage-1:0] en;
  item_t             item;
  err_t              err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_tau_q <= InvTauRst;
      gain_q    <= GainRst;
      offset_q  <= OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INV_TAU: inv_tau_q <= cfg_data_i;
        CFG_GAIN:    gain_q    <= cfg_data_i;
        CFG_OFFSET:  offset_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage k moves when empty or when the stage after it moves
  always_comb begin
    en[NStage-1] = !v_q[NStage-1] || out_o.ready;
    for (int k = NStage - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = v_q[NStage-1];

  assign item.want_w = in_i.want_w;
  assign item.want_x = in_i.want_x;
  assign item.want_y = in_i.want_y;
  assign item.want_z = in_i.want_z;
  assign item.acc_x  = in_i.acc_x;
  assign item.acc_y  = in_i.acc_y;
  assign item.acc_z  = in_i.acc_z;
  assign item.now_w  = in_i.now_w;
  assign item.now_x  = in_i.now_x;
  assign item.now_y  = in_i.now_y;
  assign item.now_z  = in_i.now_z;

  qarc_front u_front (
    .clk_i  (clk_i),
    .en_i   (en[1:0]),
    .item_i (item),
    .err_o  (err)
  );

  qarc_rate u_rate (
    .clk_i        (clk_i),
    .en_i         (en[5:2]),
    .err_i        (err),
    .inv_tau_i    (inv_tau_q),
    .roll_rate_o  (out_o.roll_rate),
    .pitch_rate_o (out_o.pitch_rate),
    .yaw_rate_o   (out_o.yaw_rate)
  );

  qarc_thrust u_thrust (
    .clk_i    (clk_i),
    .en_i     (en[5:2]),
    .err_i    (err),
    .gain_i   (gain_q),
    .offset_i (offset_q),
    .thrust_o (out_o.thrust)
  );

endmodule

FILE: hdl/qarc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_front
// Stages 0 and 1: quaternion part products, then error quaternion and body z.
// ----------------------------------------------------------------------------
module qarc_front (
  input  logic              clk_i,
  input  logic [1:0]        en_i,
  input  qarc_pkg::item_t   item_i,
  output qarc_pkg::err_t    err_o
);
  import qarc_pkg::*;

  fix16_t p [4];
  fix16_t n [4];
  prod_t  pn_q [4][4];
  prod_t  n02_q, n13_q, n23_q, n01_q, n00_q, n11_q, n22_q, n33_q;
  fix16_t ax_q, ay_q, az_q;
  err_t   err_d, err_q;

  assign p[0] = item_i.want_w;
  assign p[1] = item_i.want_x;
  assign p[2] = item_i.want_y;
  assign p[3] = item_i.want_z;
  assign n[0] = item_i.now_w;
  assign n[1] = item_i.now_x;
  assign n[2] = item_i.now_y;
  assign n[3] = item_i.now_z;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pn_q[i][j] <= prod_t'(p[i] * n[j]);
        end
      end
      n02_q <= prod_t'(n[0] * n[2]);
      n13_q <= prod_t'(n[1] * n[3]);
      n23_q <= prod_t'(n[2] * n[3]);
      n01_q <= prod_t'(n[0] * n[1]);
      n00_q <= prod_t'(n[0] * n[0]);
      n11_q <= prod_t'(n[1] * n[1]);
      n22_q <= prod_t'(n[2] * n[2]);
      n33_q <= prod_t'(n[3] * n[3]);
      ax_q  <= item_i.acc_x;
      ay_q  <= item_i.acc_y;
      az_q  <= item_i.acc_z;
    end
  end

  // error quaternion conj(now) * want with conj folded into the signs
  always_comb begin
    err_d.ew = sum_t'(pn_q[0][0]) + sum_t'(pn_q[1][1])
             + sum_t'(pn_q[2][2]) + sum_t'(pn_q[3][3]);
    err_d.ex = sum_t'(pn_q[1][0]) - sum_t'(pn_q[0][1])
             + sum_t'(pn_q[2][3]) - sum_t'(pn_q[3][2]);
    err_d.ey = sum_t'(pn_q[2][0]) - sum_t'(pn_q[0][2])
             - sum_t'(pn_q[1][3]) + sum_t'(pn_q[3][1]);
    err_d.ez = sum_t'(pn_q[3][0]) - sum_t'(pn_q[0][3])
             + sum_t'(pn_q[1][2]) - sum_t'(pn_q[2][1]);
    err_d.zx = (sum_t'(n02_q) + sum_t'(n13_q)) <<< 1;
    err_d.zy = (sum_t'(n23_q) - sum_t'(n01_q)) <<< 1;
    err_d.zz = sum_t'(n00_q) - sum_t'(n11_q) - sum_t'(n22_q) + sum_t'(n33_q);
    err_d.ax = ax_q;
    err_d.ay = ay_q;
    err_d.az = az_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;

endmodule

FILE: hdl/qarc_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_rate
// Stages 2 to 5: signed error times gain, rounding and saturation of rates.
// ----------------------------------------------------------------------------
module qarc_rate (
  input  logic                  clk_i,
  input  logic [3:0]            en_i,
  input  qarc_pkg::err_t        err_i,
  input  logic [15:0]           inv_tau_i,
  output qarc_pkg::fix16_t      roll_rate_o,
  output qarc_pkg::fix16_t      pitch_rate_o,
  output qarc_pkg::fix16_t      yaw_rate_o
);
  import qarc_pkg::*;

  typedef logic signed [RateMW-1:0] rmul_t;

  logic signed [FixW:0] it_s;
  sum_t   sx, sy, sz;
  rmul_t  mx_q, my_q, mz_q;
  fix16_t rx_q [3];
  fix16_t ry_q [3];
  fix16_t rz_q [3];

  assign it_s = $signed({1'b0, inv_tau_i});

  // zero scalar error part counts as positive
  always_comb begin
    if (err_i.ew < 0) begin
      sx = -err_i.ex;
      sy = -err_i.ey;
      sz = -err_i.ez;
    end else begin
      sx = err_i.ex;
      sy = err_i.ey;
      sz = err_i.ez;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mx_q <= rmul_t'(sx * it_s);
      my_q <= rmul_t'(sy * it_s);
      mz_q <= rmul_t'(sz * it_s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      rx_q[0] <= sat16(shr_round(wide_t'(mx_q) <<< 1, RateShift));
      ry_q[0] <= sat16(shr_round(wide_t'(my_q) <<< 1, RateShift));
      rz_q[0] <= sat16(shr_round(wide_t'(mz_q), RateShift));
    end
    for (int k = 1; k < 3; k++) begin
      if (en_i[k+1]) begin
        rx_q[k] <= rx_q[k-1];
        ry_q[k] <= ry_q[k-1];
        rz_q[k] <= rz_q[k-1];
      end
    end
  end

  assign roll_rate_o  = rx_q[2];
  assign pitch_rate_o = ry_q[2];
  assign yaw_rate_o   = rz_q[2];

endmodule

FILE: hdl/qarc_thrust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_thrust
// Stages 2 to 5: acceleration along body z, gain and offset, clamp to 0..1.
// ----------------------------------------------------------------------------
module qarc_thrust (
  input  logic              clk_i,
  input  logic [3:0]        en_i,
  input  qarc_pkg::err_t    err_i,
  input  logic [15:0]       gain_i,
  input  logic [15:0]       offset_i,
  output qarc_pkg::thr_t    thrust_o
);
  import qarc_pkg::*;

  typedef logic signed [DotMW-1:0] dmul_t;
  typedef logic signed [AccW-1:0]  acc_t;
  typedef logic signed [ThrMW-1:0] tmul_t;

  dmul_t dx_q, dy_q, dz_q;
  wide_t dot;
  acc_t  acc_q;
  tmul_t t_q;
  wide_t t_w;
  wide_t t_r;
  thr_t  thr_d, thr_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dx_q <= dmul_t'(err_i.ax * err_i.zx);
      dy_q <= dmul_t'(err_i.ay * err_i.zy);
      dz_q <= dmul_t'(err_i.az * err_i.zz);
    end
  end

  assign dot = wide_t'(dx_q) + wide_t'(dy_q) + wide_t'(dz_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      acc_q <= acc_t'(shr_round(dot, DotShift));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      t_q <= tmul_t'(acc_q * $signed({1'b0, gain_i}))
           + tmul_t'({1'b0, offset_i, {OffShift{1'b0}}});
    end
  end

  assign t_w = wide_t'(t_q);
  assign t_r = (t_w + (wide_t'(1) <<< (ThrShift - 1))) >>> ThrShift;

  always_comb begin
    if (t_w <= 0) begin
      thr_d = '0;
    end else if (t_r > wide_t'({1'b0, ThrFull})) begin
      thr_d = ThrFull;
    end else begin
      thr_d = t_r[ThrW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      thr_q <= thr_d;
    end
  end

  assign thrust_o = thr_q;

endmodule

FILE: test/qarc_cmd_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qarc_cmd_check
// Watches the register port and both channels of the attitude rate
// controller. Each pose transfer is turned into the rate and thrust command
// the block must produce, and each command transfer is compared against the
// oldest command still owed.
// ----------------------------------------------------------------------------
module qarc_cmd_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qarc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [qarc_pkg::FixW-1:0]    cfg_data_i,
  qarc_in_if                           pose_i,
  qarc_out_if                          cmd_i,
  output int                           mismatch_cnt_o,
  output int                           owed_cnt_o,
  output int                           compared_cnt_o
);
  import qarc_pkg::*;

  typedef struct packed {
    fix16_t roll;
    fix16_t pitch;
    fix16_t yaw;
    thr_t   thrust;
  } attitude_cmd_t;

  localparam logic [15:0] TauAtReset    = 16'd2560;
  localparam logic [15:0] GainAtReset   = 16'd4588;
  localparam logic [15:0] OffsetAtReset = 16'd6554;
  localparam longint RateHi    = 64'sd32767;
  localparam longint RateLo    = -64'sd32768;
  localparam longint ThrustCap = 64'sd4096;
  localparam int     ReportMax = 10;

  logic [15:0]   inv_tau;
  logic [15:0]   thr_gain;
  logic [15:0]   thr_offset;
  attitude_cmd_t owed_cmds[$];
  attitude_cmd_t exp_cmd;
  attitude_cmd_t got_cmd;
  item_t         pose;
  int            n_bad;
  int            n_done;

  // shift right, round half away from zero
  function automatic longint round_shift(longint v, int unsigned n);
    longint half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 64'sd0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  function automatic fix16_t clip_rate(longint v);
    if (v > RateHi) begin
      return 16'sh7fff;
    end
    if (v < RateLo) begin
      return 16'sh8000;
    end
    return fix16_t'(v);
  endfunction

  function automatic attitude_cmd_t rate_thrust_of(item_t p);
    longint w0, w1, w2, w3, n0, n1, n2, n3, c1, c2, c3;
    longint ew, ex, ey, ez, sgn, tau;
    longint zx, zy, zz, dotp, acc_q16, thr_q32, thr;
    attitude_cmd_t r;
    w0 = longint'(p.want_w);
    w1 = longint'(p.want_x);
    w2 = longint'(p.want_y);
    w3 = longint'(p.want_z);
    n0 = longint'(p.now_w);
    n1 = longint'(p.now_x);
    n2 = longint'(p.now_y);
    n3 = longint'(p.now_z);
    c1 = -n1;
    c2 = -n2;
    c3 = -n3;
    // error quaternion conj(now) * want, exact in Q6.28
    ew = w0 * n0 - w1 * c1 - w2 * c2 - w3 * c3;
    ex = w0 * c1 + w1 * n0 - w2 * c3 + w3 * c2;
    ey = w0 * c2 + w1 * c3 + w2 * n0 - w3 * c1;
    ez = w0 * c3 - w1 * c2 + w2 * c1 + w3 * n0;
    // zero scalar error part takes the positive branch
    sgn = (ew >= 64'sd0) ? 64'sd1 : -64'sd1;
    tau = longint'(inv_tau);
    r.roll  = clip_rate(round_shift(64'sd2 * tau * sgn * ex, RateShift));
    r.pitch = clip_rate(round_shift(64'sd2 * tau * sgn * ey, RateShift));
    r.yaw   = clip_rate(round_shift(tau * sgn * ez, RateShift));
    // body z axis of the current attitude
    zx = 64'sd2 * (n0 * n2 + n1 * n3);
    zy = 64'sd2 * (n2 * n3 - n0 * n1);
    zz = n0 * n0 - n1 * n1 - n2 * n2 + n3 * n3;
    dotp = longint'(p.acc_x) * zx + longint'(p.acc_y) * zy + longint'(p.acc_z) * zz;
    acc_q16 = round_shift(dotp, DotShift);
    thr_q32 = longint'(thr_gain) * acc_q16 + (longint'(thr_offset) <<< OffShift);
    if (thr_q32 <= 64'sd0) begin
      thr = 64'sd0;
    end else begin
      thr = (thr_q32 + (64'sd1 <<< (ThrShift - 1))) >>> ThrShift;
      if (thr > ThrustCap) begin
        thr = ThrustCap;
      end
    end
    r.thrust = thr_t'(thr);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_tau    = TauAtReset;
      thr_gain   = GainAtReset;
      thr_offset = OffsetAtReset;
      owed_cmds.delete();
      n_bad  = 0;
      n_done = 0;
      mismatch_cnt_o <= 0;
      owed_cnt_o     <= 0;
      compared_cnt_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INV_TAU: inv_tau = cfg_data_i;
          CFG_GAIN:    thr_gain = cfg_data_i;
          CFG_OFFSET:  thr_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        got_cmd = {cmd_i.roll_rate, cmd_i.pitch_rate, cmd_i.yaw_rate, cmd_i.thrust};
        if (owed_cmds.size() == 0) begin
          n_bad++;
          if (n_bad <= ReportMax) begin
            $display("%0t: command transfer with none owed: roll %0d pitch %0d yaw %0d thrust %0d",
                     $realtime, got_cmd.roll, got_cmd.pitch, got_cmd.yaw, got_cmd.thrust);
          end
        end else begin
          exp_cmd = owed_cmds.pop_front();
          n_done++;
          if (got_cmd.roll !== exp_cmd.roll || got_cmd.pitch !== exp_cmd.pitch ||
              got_cmd.yaw !== exp_cmd.yaw || got_cmd.thrust !== exp_cmd.thrust) begin
            n_bad++;
            if (n_bad <= ReportMax) begin
              $display("%0t: command %0d mismatch", $realtime, n_done);
              $display("  expected roll %0d pitch %0d yaw %0d thrust %0d",
                       exp_cmd.roll, exp_cmd.pitch, exp_cmd.yaw, exp_cmd.thrust);
              $display("  actual   roll %0d pitch %0d yaw %0d thrust %0d",
                       got_cmd.roll, got_cmd.pitch, got_cmd.yaw, got_cmd.thrust);
            end
          end
        end
      end
      if (pose_i.valid && pose_i.ready) begin
        pose = {pose_i.want_w, pose_i.want_x, pose_i.want_y, pose_i.want_z,
                pose_i.acc_x, pose_i.acc_y, pose_i.acc_z,
                pose_i.now_w, pose_i.now_x, pose_i.now_y, pose_i.now_z};
        owed_cmds.push_back(rate_thrust_of(pose));
      end
      mismatch_cnt_o <= n_bad;
      owed_cnt_o     <= owed_cmds.size();
      compared_cnt_o <= n_done;
    end
  end

endmodule

FILE: test/quaternion_attitude_rate_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_attitude_rate_controller_tb
// Drives pose pairs into the attitude rate controller under several register
// settings, with random idle gaps on the input and random stalls on the
// output. A short directed set hits the extremes and the zero scalar error
// case; the bulk are near-unit pose pairs plus raw and extreme-valued noise.
// Checking is done by qarc_cmd_check.
// ----------------------------------------------------------------------------
module quaternion_attitude_rate_controller_tb;
  import qarc_pkg::*;

  typedef struct packed {
    fix16_t w;
    fix16_t x;
    fix16_t y;
    fix16_t z;
  } quat_t;

  localparam int NumPhases    = 6;
  localparam int RandPerPhase = 170;
  localparam int PipeDepth    = 6;
  localparam int NumFields    = 11;
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [FixW-1:0]    cfg_data_i;
  logic               tx_calm;
  logic               rx_calm;
  int                 n_sent;
  int                 mismatches;
  int                 owed;
  int                 compared;

  qarc_in_if  pose_if ();
  qarc_out_if cmd_if ();

  quaternion_attitude_rate_controller dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pose_if),
    .out_o      (cmd_if)
  );

  qarc_cmd_check u_cmd_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pose_i         (pose_if),
    .cmd_i          (cmd_if),
    .mismatch_cnt_o (mismatches),
    .owed_cnt_o     (owed),
    .compared_cnt_o (compared)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("quaternion_attitude_rate_controller regression: fail");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 3);
    end
    if (r < 93) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic fix16_t rand_fix();
    return fix16_t'($urandom_range(0, 65535));
  endfunction

  function automatic fix16_t edge_fix();
    case ($urandom_range(0, 6))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      5: return 16'sh4000;
      default: return 16'shc000;
    endcase
  endfunction

  function automatic real unit_rand();
    return ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
  endfunction

  function automatic quat_t to_q214(real a, real b, real c, real d);
    real n;
    real s;
    quat_t q;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0e-3) begin
      q = {16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000};
    end else begin
      s = 16384.0 / n;
      q.w = fix16_t'($rtoi(a * s));
      q.x = fix16_t'($rtoi(b * s));
      q.y = fix16_t'($rtoi(c * s));
      q.z = fix16_t'($rtoi(d * s));
    end
    return q;
  endfunction

  function automatic item_t pose(int ww, int wx, int wy, int wz, int ax, int ay, int az,
                                 int nw, int nx, int ny, int nz);
    item_t p;
    p.want_w = fix16_t'(ww);
    p.want_x = fix16_t'(wx);
    p.want_y = fix16_t'(wy);
    p.want_z = fix16_t'(wz);
    p.acc_x  = fix16_t'(ax);
    p.acc_y  = fix16_t'(ay);
    p.acc_z  = fix16_t'(az);
    p.now_w  = fix16_t'(nw);
    p.now_x  = fix16_t'(nx);
    p.now_y  = fix16_t'(ny);
    p.now_z  = fix16_t'(nz);
    return p;
  endfunction

  function automatic item_t random_pose();
    item_t p;
    quat_t cur;
    quat_t des;
    real   a, b, c, d, eps;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      // near-unit attitudes with a small to moderate error
      a = unit_rand();
      b = unit_rand();
      c = unit_rand();
      d = unit_rand();
      cur = to_q214(a, b, c, d);
      eps = $itor($urandom_range(1, 60)) / 100.0;
      des = to_q214(a + eps * unit_rand(), b + eps * unit_rand(),
                    c + eps * unit_rand(), d + eps * unit_rand());
      if ($urandom_range(0, 3) == 0) begin
        des.w = -des.w;
        des.x = -des.x;
        des.y = -des.y;
        des.z = -des.z;
      end
      p.want_w = des.w;
      p.want_x = des.x;
      p.want_y = des.y;
      p.want_z = des.z;
      p.now_w  = cur.w;
      p.now_x  = cur.x;
      p.now_y  = cur.y;
      p.now_z  = cur.z;
      if ($urandom_range(0, 4) == 0) begin
        p.acc_x = rand_fix();
        p.acc_y = rand_fix();
        p.acc_z = rand_fix();
      end else begin
        p.acc_x = fix16_t'(int'($urandom_range(0, 2560)) - 1280);
        p.acc_y = fix16_t'(int'($urandom_range(0, 2560)) - 1280);
        p.acc_z = fix16_t'(int'($urandom_range(0, 2560)) + 1231);
      end
    end else if (r < 85) begin
      for (int i = 0; i < NumFields; i++) begin
        p[i*FixW +: FixW] = rand_fix();
      end
    end else begin
      for (int i = 0; i < NumFields; i++) begin
        p[i*FixW +: FixW] = ($urandom_range(0, 1) == 1) ? edge_fix() : rand_fix();
      end
    end
    return p;
  endfunction

  task automatic send_pose(item_t p);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
    if (gap != 0) begin
      pose_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    {pose_if.want_w, pose_if.want_x, pose_if.want_y, pose_if.want_z,
     pose_if.acc_x, pose_if.acc_y, pose_if.acc_z,
     pose_if.now_w, pose_if.now_x, pose_if.now_y, pose_if.now_z} <= p;
    pose_if.valid <= 1'b1;
    do @(posedge clk_i); while (!pose_if.ready);
    n_sent++;
  endtask

  task automatic drain();
    pose_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed != 0);
  endtask

  task automatic program_regs(logic [FixW-1:0] tau, logic [FixW-1:0] gain,
                              logic [FixW-1:0] offset);
    drain();
    repeat (PipeDepth + 2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_INV_TAU;
    cfg_data_i <= tau;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GAIN;
    cfg_data_i <= gain;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OFFSET;
    cfg_data_i <= offset;
    @(posedge clk_i);
    // index past the last register must leave all three alone
    cfg_idx_i  <= CfgSpare;
    cfg_data_i <= rand_fix();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_directed();
    send_pose(pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pose(pose(16384, 0, 0, 0, 0, 0, 2511, 16384, 0, 0, 0));
    // zero scalar error part on each axis
    send_pose(pose(0, 16384, 0, 0, 0, 0, 2511, 16384, 0, 0, 0));
    send_pose(pose(0, 0, 16384, 0, 0, 0, 2511, 16384, 0, 0, 0));
    send_pose(pose(0, 0, 0, 16384, 0, 0, 2511, 16384, 0, 0, 0));
    send_pose(pose(0, -16384, 0, 0, 0, 0, 2511, 16384, 0, 0, 0));
    // negative scalar error part
    send_pose(pose(-16000, -3000, 2000, -1000, 300, -300, 2511, 16384, 0, 0, 0));
    send_pose(pose(-8192, -8192, -8192, -8192, 0, 0, 2511, 8192, 8192, 8192, 8192));
    send_pose(pose(11585, 11585, 0, 0, 0, 0, 2511, 16384, 0, 0, 0));
    send_pose(pose(16384, 0, 0, 0, 2511, 0, 2511, 11585, 0, 11585, 0));
    send_pose(pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                   32767, 32767, 32767, 32767));
    send_pose(pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                   -32768, -32768, -32768, -32768));
    send_pose(pose(-32768, -32768, -32768, -32768, 32767, -32768, 32767,
                   32767, 32767, 32767, 32767));
    send_pose(pose(32767, -32768, 32767, -32768, -32768, 32767, -32768,
                   -32768, 32767, -32768, 32767));
    // thrust clamps at both ends
    send_pose(pose(16384, 0, 0, 0, 0, 0, -32768, 16384, 0, 0, 0));
    send_pose(pose(16384, 0, 0, 0, 0, 0, 32767, 16384, 0, 0, 0));
    send_pose(pose(0, 16384, 0, 0, 32767, -32768, 32767, 0, 16384, 0, 0));
    send_pose(pose(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    send_pose(pose(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1));
    // unnormalized attitudes
    send_pose(pose(32767, 32767, 0, 0, 0, 0, 2511, 32767, 0, 0, 0));
  endtask

  initial begin : cmd_sink
    int stall_left;
    stall_left = 0;
    cmd_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        cmd_if.ready <= 1'b0;
      end else if (stall_left != 0) begin
        cmd_if.ready <= 1'b0;
        stall_left--;
      end else begin
        cmd_if.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 99) < 25) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  initial begin
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_INV_TAU;
    cfg_data_i = '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    n_sent     = 0;
    pose_if.valid = 1'b0;
    {pose_if.want_w, pose_if.want_x, pose_if.want_y, pose_if.want_z,
     pose_if.acc_x, pose_if.acc_y, pose_if.acc_z,
     pose_if.now_w, pose_if.now_x, pose_if.now_y, pose_if.now_z} = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: ;
        1: program_regs(16'h0000, 16'h0000, 16'h0000);
        2: program_regs(16'hffff, 16'hffff, 16'hffff);
        3: program_regs(16'h0001, 16'hffff, 16'h0000);
        default: program_regs(rand_fix(), rand_fix(), rand_fix());
      endcase
      tx_calm = (ph == 1);
      rx_calm <= (ph == 1 || ph == 4);
      if (ph == 0) begin
        send_directed();
      end
      for (int i = 0; i < RandPerPhase; i++) begin
        if (i == RandPerPhase / 2) begin
          drain();
        end
        send_pose(random_pose());
      end
    end

    drain();
    repeat (PipeDepth + 4) @(posedge clk_i);
    $display("sent %0d pose pairs over %0d register settings, gaps and stalls on both sides",
             n_sent, NumPhases);
    $display("compared %0d commands, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && owed == 0) begin
      $display("quaternion_attitude_rate_controller regression: pass");
    end else begin
      $display("quaternion_attitude_rate_controller regression: fail");
    end
    $finish;
  end

endmodule
